### hw/rtl/cdq_pkg.sv
`default_nettype none
// ============================================================================
// cdq_pkg
// Shared types and codes for the circular double-ended queue.
// ============================================================================
package cdq_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 4;

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_REAR   = 3'd3;
    localparam logic [2:0] CMD_STATUS     = 3'd4;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [WORD_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] popped_value;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic                     not_empty;
        logic                     is_full;
        logic [COUNT_W-1:0]       element_count;
    } rsp_t;

endpackage
`default_nettype wire

### hw/rtl/cdq_ram.sv
`default_nettype none
// ============================================================================
// cdq_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/cdq_ctrl.sv
`default_nettype none
// ============================================================================
// cdq_ctrl
// Pointer, occupancy and end-value bookkeeping; drives the slot RAM.
// ============================================================================
module cdq_ctrl #(
    parameter int DEPTH = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire cdq_pkg::req_t                         request,
    output logic                                       valid,
    output cdq_pkg::rsp_t                              result,
    output logic                                       ram_we,
    output logic [$clog2(DEPTH)-1:0]                   ram_waddr,
    output logic [cdq_pkg::WORD_W-1:0]                 ram_wdata,
    output logic                                       ram_re,
    output logic [$clog2(DEPTH)-1:0]                   ram_raddr,
    input  wire logic [cdq_pkg::WORD_W-1:0]            ram_rdata
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (OCC_W > cdq_pkg::COUNT_W) ? OCC_W : cdq_pkg::COUNT_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                              state_reg, state_next;
    logic [IDX_W-1:0]                  head_reg, head_next;
    logic [IDX_W-1:0]                  tail_reg, tail_next;
    logic [OCC_W-1:0]                  occ_reg, occ_next;
    logic signed [cdq_pkg::WORD_W-1:0] front_reg, front_next;
    logic signed [cdq_pkg::WORD_W-1:0] rear_reg, rear_next;
    logic                              fetch_front_reg, fetch_front_next;
    logic                              valid_reg, valid_next;
    cdq_pkg::rsp_t                     res_reg, res_next;
    logic [1:0]                        status_v;
    logic signed [cdq_pkg::WORD_W-1:0] popped_v;
    logic                              fetch_v;
    logic [EXT_W-1:0]                  occ_ext;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        occ_next         = occ_reg;
        front_next       = front_reg;
        rear_next        = rear_reg;
        fetch_front_next = fetch_front_reg;
        status_v         = res_reg.status;
        popped_v         = res_reg.popped_value;
        fetch_v          = 1'b0;
        valid_next       = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = head_reg;
        ram_wdata        = request.push_value;
        ram_re           = 1'b0;
        ram_raddr        = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    status_v = cdq_pkg::STAT_DONE;
                    popped_v = '0;
                    case (request.command)
                        cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR:
                        begin
                            if (occ_reg == OCC_W'(DEPTH))
                            begin
                                status_v = cdq_pkg::STAT_OVERFLOW;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                occ_next = occ_reg + 1'b1;
                                if (occ_reg == '0)
                                begin
                                    head_next  = '0;
                                    tail_next  = '0;
                                    ram_waddr  = '0;
                                    front_next = request.push_value;
                                    rear_next  = request.push_value;
                                end
                                else if (request.command == cdq_pkg::CMD_PUSH_FRONT)
                                begin
                                    head_next  = wrap_dec(head_reg);
                                    ram_waddr  = head_next;
                                    front_next = request.push_value;
                                end
                                else
                                begin
                                    tail_next = wrap_inc(tail_reg);
                                    ram_waddr = tail_next;
                                    rear_next = request.push_value;
                                end
                            end
                        end
                        cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_v = cdq_pkg::STAT_UNDERFLOW;
                            end
                            else
                            begin
                                occ_next = occ_reg - 1'b1;
                                if (request.command == cdq_pkg::CMD_POP_FRONT)
                                begin
                                    popped_v = front_reg;
                                    if (occ_reg > OCC_W'(1))
                                    begin
                                        head_next        = wrap_inc(head_reg);
                                        ram_raddr        = head_next;
                                        fetch_v          = 1'b1;
                                        fetch_front_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    popped_v = rear_reg;
                                    if (occ_reg > OCC_W'(1))
                                    begin
                                        tail_next        = wrap_dec(tail_reg);
                                        ram_raddr        = tail_next;
                                        fetch_v          = 1'b1;
                                        fetch_front_next = 1'b0;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            status_v = cdq_pkg::STAT_DONE;
                        end
                    endcase
                    ram_re     = fetch_v;
                    valid_next = !fetch_v;
                    state_next = fetch_v ? ST_READ : ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (fetch_front_reg)
                begin
                    front_next = ram_rdata;
                end
                else
                begin
                    rear_next = ram_rdata;
                end
                valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        occ_ext                = EXT_W'(occ_next);
        res_next.status        = status_v;
        res_next.popped_value  = popped_v;
        res_next.front_value   = (occ_next != '0) ? front_next : '0;
        res_next.rear_value    = (occ_next != '0) ? rear_next : '0;
        res_next.not_empty     = (occ_next != '0);
        res_next.is_full       = (occ_next == OCC_W'(DEPTH));
        res_next.element_count = occ_ext[cdq_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg       <= front_next;
        rear_reg        <= rear_next;
        fetch_front_reg <= fetch_front_next;
        res_reg         <= res_next;
    end

    assign busy   = (state_reg == ST_READ);
    assign valid  = valid_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

### hw/rtl/circular_double_ended_queue_top.sv
`default_nettype none
// ============================================================================
// circular_double_ended_queue_top
// Double-ended queue of signed 32-bit words kept in a circular slot RAM.
// ============================================================================
// A request is taken when start is high and busy is low. Pushes, status
// requests, rejected requests and a pop of the last element give their
// result in the cycle after acceptance, and busy stays low, so one such
// request can be taken every cycle. A pop that leaves elements behind reads
// the new end element from the slot RAM's registered read port: busy is
// high for a single cycle and no request is taken meanwhile; the result
// passes the RAM read register, then the result register. Each result is
// shown for exactly one cycle with valid high and cannot be held off.
module circular_double_ended_queue_top #(
    parameter int DEPTH = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire cdq_pkg::req_t request,
    output logic               valid,
    output cdq_pkg::rsp_t      result
);

    localparam int IDX_W = $clog2(DEPTH);

    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [cdq_pkg::WORD_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [IDX_W-1:0]           ram_raddr;
    logic [cdq_pkg::WORD_W-1:0] ram_rdata;

    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .valid     (valid),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    cdq_ram #(
        .WIDTH (cdq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

### hw/rtl/cdq_checker.sv
`default_nettype none
// ============================================================================
// cdq_checker
// Port-level checks on the request and result sequencing of the queue.
// ============================================================================
module cdq_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire cdq_pkg::req_t request,
    input wire logic          valid,
    input wire cdq_pkg::rsp_t result
);

    a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> valid || busy)
        else $error("Accepted request produced neither a result nor a busy cycle.");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy && valid)
        else $error("Busy phase did not end with a result after one cycle.");

    a_status_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.command == cdq_pkg::CMD_STATUS |=> valid && !busy)
        else $error("Status request did not answer in the next cycle.");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(start && !busy) || $past(busy))
        else $error("Result appeared without a pending request.");

    a_flags_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.status == cdq_pkg::STAT_UNDERFLOW |-> !result.not_empty)
        else $error("Underflow reported while the queue holds elements.");

endmodule

bind circular_double_ended_queue_top cdq_checker u_cdq_checker (.*);
`default_nettype wire
